// ===== rtl/anms_pkg.sv =====
package anms_pkg;

  localparam int unsigned MAX_POINTS = 64;
  localparam int unsigned XW   = 16;
  localparam int unsigned SW   = 32;
  localparam int unsigned RW   = 34;
  localparam int unsigned CFGW = 7;

  localparam logic [RW-1:0] RADIUS_INF = {RW{1'b1}};

  typedef struct packed {
    logic [XW-1:0] x;
    logic [XW-1:0] y;
    logic [SW-1:0] s;
    logic          last;
  } point_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_RAD_RD,
    ST_RAD,
    ST_RANK_RD,
    ST_RANK,
    ST_EMIT,
    ST_PASS
  } state_t;

  function automatic logic [SW-1:0] skey(input logic [SW-1:0] s);
    return s ^ {1'b1, {(SW-1){1'b0}}};
  endfunction

endpackage

// ===== rtl/anms_front.sv =====
module anms_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [15:0]           in_pos_x,
  input  logic [15:0]           in_pos_y,
  input  logic signed [31:0]    in_strength,
  input  logic                  in_set_end,
  output logic                  q_valid,
  input  logic                  q_ready,
  output anms_pkg::point_t      q_data
);
  import anms_pkg::*;

  // two-entry queue decouples intake from the set processor
  point_t      buf_r [2];
  logic        wp_r, rp_r;
  logic [1:0]  cnt_r;
  logic        push, pop;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_data   = buf_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wp_r] <= '{x: in_pos_x, y: in_pos_y, s: in_strength, last: in_set_end};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== rtl/anms_back.sv =====
module anms_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [6:0]            max_features,
  input  logic                  q_valid,
  output logic                  q_ready,
  input  anms_pkg::point_t      q_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [15:0]           out_x,
  output logic [15:0]           out_y,
  output logic signed [31:0]    out_strength,
  output logic [5:0]            out_source_index,
  output logic                  out_run_end
);
  import anms_pkg::*;

  localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);

  logic [XW-1:0] xs_m [MAX_POINTS];
  logic [XW-1:0] ys_m [MAX_POINTS];
  logic [SW-1:0] ss_m [MAX_POINTS];
  logic [RW-1:0] rs_m [MAX_POINTS];

  state_t        st_r, st_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic [AW-1:0] i_r, i_nxt, j_r, j_nxt;
  logic [CW-1:0] slot_r, slot_nxt;   // output rank being searched
  logic [CW-1:0] cnt_r, cnt_nxt;     // points ranked before i
  logic [RW-1:0] best_r, best_nxt;
  logic [CW-1:0] take_r, take_nxt;

  // registered memory reads
  logic [XW-1:0] xi_r, xj_r, yi_r, yj_r;
  logic [SW-1:0] si_r, sj_r;
  logic [RW-1:0] ri_r, rj_r;
  logic          jv_r;
  logic [AW-1:0] jd_r;

  logic          ob_v_r;
  logic [XW-1:0] ob_x_r, ob_y_r;
  logic [SW-1:0] ob_s_r;
  logic [5:0]    ob_i_r;
  logic          ob_e_r;

  logic [XW-1:0] dx, dy;
  logic [RW-1:0] d2;
  logic          better;
  logic          jbefore;
  logic          mem_we, rad_we, emit_go;
  logic [AW-1:0] rd_j;
  logic [AW-1:0] emit_idx;
  logic          emit_last;

  assign dx = (xi_r > xj_r) ? xi_r - xj_r : xj_r - xi_r;
  assign dy = (yi_r > yj_r) ? yi_r - yj_r : yj_r - yi_r;
  assign d2 = RW'({1'b0, dx} * {1'b0, dx}) + RW'({1'b0, dy} * {1'b0, dy});

  assign better = jv_r && (skey(sj_r) > skey(si_r)) && (d2 < best_r);

  assign jbefore = (rj_r != ri_r) ? (rj_r > ri_r)
                 : (skey(sj_r) != skey(si_r)) ? (skey(sj_r) > skey(si_r))
                 : (jd_r < i_r);

  assign out_valid        = ob_v_r;
  assign out_x            = ob_x_r;
  assign out_y            = ob_y_r;
  assign out_strength     = ob_s_r;
  assign out_source_index = ob_i_r;
  assign out_run_end      = ob_e_r;

  always_comb begin
    st_nxt    = st_r;
    n_nxt     = n_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    slot_nxt  = slot_r;
    cnt_nxt   = cnt_r;
    best_nxt  = best_r;
    take_nxt  = take_r;
    q_ready   = 1'b0;
    mem_we    = 1'b0;
    rad_we    = 1'b0;
    emit_go   = 1'b0;
    emit_idx  = i_r;
    emit_last = 1'b0;
    rd_j      = j_r;
    case (st_r)
      ST_LOAD: begin
        q_ready = 1'b1;
        if (q_valid) begin
          mem_we = (n_r < CW'(MAX_POINTS));
          if (mem_we) n_nxt = n_r + CW'(1);
          if (q_data.last) begin
            i_nxt = '0;
            j_nxt = '0;
            if (n_nxt == '0) begin
              st_nxt = ST_LOAD;
            end else if (max_features == 7'd0 || 32'(n_nxt) <= 32'(max_features)) begin
              take_nxt = n_nxt;
              st_nxt   = ST_PASS;
            end else begin
              take_nxt = CW'(max_features);
              best_nxt = RADIUS_INF;
              st_nxt   = ST_RAD_RD;
            end
          end
        end
      end
      ST_RAD_RD: begin
        rd_j   = '0;
        j_nxt  = AW'(1);
        st_nxt = ST_RAD;
      end
      ST_RAD: begin
        // jv_r/jd_r describe the pair currently in the read registers
        if (better) best_nxt = d2;
        if (jv_r && 32'(jd_r) == 32'(n_r) - 1) begin
          rad_we   = 1'b1;
          best_nxt = RADIUS_INF;
          if (32'(i_r) == 32'(n_r) - 1) begin
            i_nxt    = '0;
            slot_nxt = '0;
            cnt_nxt  = '0;
            st_nxt   = ST_RANK_RD;
          end else begin
            i_nxt  = i_r + AW'(1);
            st_nxt = ST_RAD_RD;
          end
        end else begin
          j_nxt = j_r + AW'(1);
        end
      end
      ST_RANK_RD: begin
        rd_j    = '0;
        j_nxt   = AW'(1);
        cnt_nxt = '0;
        st_nxt  = ST_RANK;
      end
      ST_RANK: begin
        if (jv_r && jd_r != i_r && jbefore) cnt_nxt = cnt_r + CW'(1);
        if (jv_r && 32'(jd_r) == 32'(n_r) - 1) begin
          if (cnt_nxt == slot_r) begin
            st_nxt = ST_EMIT;
          end else begin
            i_nxt  = (32'(i_r) == 32'(n_r) - 1) ? '0 : i_r + AW'(1);
            st_nxt = ST_RANK_RD;
          end
        end else begin
          j_nxt = j_r + AW'(1);
        end
      end
      ST_EMIT: begin
        emit_idx  = i_r;
        rd_j      = i_r;
        emit_last = (slot_r + CW'(1) == take_r);
        if (!ob_v_r || out_ready) begin
          emit_go = 1'b1;
          if (emit_last) begin
            n_nxt  = '0;
            st_nxt = ST_LOAD;
          end else begin
            slot_nxt = slot_r + CW'(1);
            i_nxt    = '0;
            st_nxt   = ST_RANK_RD;
          end
        end
      end
      ST_PASS: begin
        emit_idx  = i_r;
        rd_j      = i_r;
        emit_last = (32'(i_r) + 1 == 32'(take_r));
        if (!ob_v_r || out_ready) begin
          emit_go = 1'b1;
          i_nxt   = i_r + AW'(1);
          if (emit_last) begin
            n_nxt  = '0;
            st_nxt = ST_LOAD;
          end
        end
      end
      default: st_nxt = ST_LOAD;
    endcase
  end

  // two read addresses per cycle: i side and j side; emit shares the j side
  always_ff @(posedge clk) begin
    if (mem_we) begin
      xs_m[n_r[AW-1:0]] <= q_data.x;
      ys_m[n_r[AW-1:0]] <= q_data.y;
      ss_m[n_r[AW-1:0]] <= q_data.s;
    end
    if (rad_we) rs_m[i_r] <= better ? d2 : best_r;
    xi_r <= xs_m[i_nxt];
    yi_r <= ys_m[i_nxt];
    si_r <= ss_m[i_nxt];
    ri_r <= rs_m[i_nxt];
    xj_r <= xs_m[rd_j];
    yj_r <= ys_m[rd_j];
    sj_r <= ss_m[rd_j];
    rj_r <= rs_m[rd_j];
    jd_r <= rd_j;
    if (emit_go) begin
      ob_x_r <= xs_m[rd_j];
      ob_y_r <= ys_m[rd_j];
      ob_s_r <= ss_m[rd_j];
      ob_i_r <= 6'(emit_idx);
      ob_e_r <= emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_LOAD;
      n_r    <= '0;
      i_r    <= '0;
      j_r    <= '0;
      slot_r <= '0;
      cnt_r  <= '0;
      best_r <= RADIUS_INF;
      take_r <= '0;
      jv_r   <= 1'b0;
      ob_v_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      n_r    <= n_nxt;
      i_r    <= i_nxt;
      j_r    <= j_nxt;
      slot_r <= slot_nxt;
      cnt_r  <= cnt_nxt;
      best_r <= best_nxt;
      take_r <= take_nxt;
      jv_r   <= (st_nxt == ST_RAD || st_nxt == ST_RANK) &&
                !((st_r == ST_RAD || st_r == ST_RANK) && jv_r && 32'(jd_r) == 32'(n_r) - 1);
      if (emit_go)        ob_v_r <= 1'b1;
      else if (out_ready) ob_v_r <= 1'b0;
    end
  end

endmodule

// ===== rtl/adaptive_nonmax_suppression.sv =====
// A set is loaded one point per cycle while the back end is collecting points and the
// queue has room; when it closes with more points than a nonzero max_features, a radius
// pass scans every pair, then each output rank is found by a ranking scan and emitted.
// Pass-through sets are emitted in load order, one point per cycle while out_ready
// allows. Each stored point takes one memory write.
// Reset (synchronous, rst_n low) clears the point count, state, queue and max_features.
module adaptive_nonmax_suppression (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [6:0]         cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        in_pos_x,
  input  logic [15:0]        in_pos_y,
  input  logic signed [31:0] in_strength,
  input  logic               in_set_end,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        out_x,
  output logic [15:0]        out_y,
  output logic signed [31:0] out_strength,
  output logic [5:0]         out_source_index,
  output logic               out_run_end
);
  import anms_pkg::*;

  logic [6:0] max_features_r;
  logic       q_valid, q_ready;
  point_t     q_data;

  always_ff @(posedge clk) begin
    if (!rst_n) max_features_r <= '0;
    else if (cfg_we) max_features_r <= cfg_wdata;
  end

  anms_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_pos_x, .in_pos_y, .in_strength,
    .in_set_end, .q_valid, .q_ready, .q_data
  );

  anms_back u_back (
    .clk, .rst_n, .max_features(max_features_r), .q_valid, .q_ready, .q_data,
    .out_valid, .out_ready, .out_x, .out_y, .out_strength, .out_source_index,
    .out_run_end
  );

endmodule

// ===== dv/tb_adaptive_nonmax_suppression.sv =====
module tb_adaptive_nonmax_suppression;
  timeunit 1ns;
  timeprecision 1ps;
  import anms_pkg::*;

  localparam int NPTS = MAX_POINTS;
  localparam int WATCHDOG_LIMIT = 2000000;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [31:0] s;
    logic [5:0]  idx;
    logic        run_end;
  } kp_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [6:0]  cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [15:0] in_pos_x = '0;
  logic [15:0] in_pos_y = '0;
  logic signed [31:0] in_strength = '0;
  logic        in_set_end = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] out_x;
  logic [15:0] out_y;
  logic signed [31:0] out_strength;
  logic [5:0]  out_source_index;
  logic        out_run_end;

  adaptive_nonmax_suppression dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_pos_x(in_pos_x),
    .in_pos_y(in_pos_y), .in_strength(in_strength), .in_set_end(in_set_end),
    .out_valid(out_valid), .out_ready(out_ready), .out_x(out_x), .out_y(out_y),
    .out_strength(out_strength), .out_source_index(out_source_index),
    .out_run_end(out_run_end)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  logic [15:0]   kp_x [NPTS];
  logic [15:0]   kp_y [NPTS];
  logic [31:0]   kp_s [NPTS];
  logic [RW-1:0] kp_rad [NPTS];
  int            kp_count;
  int            keep_limit;

  kp_result_t selected_q[$];
  int  errors;
  int  send_idle_pct;
  int  recv_idle_pct;
  int  idle_cycles;
  bit  timed_out;

  function automatic bit outranks(int a, int b);
    if (kp_rad[a] != kp_rad[b]) return kp_rad[a] > kp_rad[b];
    if (skey(kp_s[a]) != skey(kp_s[b])) return skey(kp_s[a]) > skey(kp_s[b]);
    return a < b;
  endfunction

  function automatic void push_point(int p, bit last);
    kp_result_t r;
    r.x = kp_x[p];
    r.y = kp_y[p];
    r.s = kp_s[p];
    r.idx = p[5:0];
    r.run_end = last;
    selected_q.insert(selected_q.size(), r);
  endfunction

  function automatic void predict_selection(logic [15:0] x, logic [15:0] y,
                                            logic [31:0] s, logic e);
    int n;
    int slot [NPTS];
    logic [RW-1:0] best, d2;
    logic [15:0] dx, dy;
    int r;
    if (kp_count < NPTS) begin
      kp_x[kp_count] = x;
      kp_y[kp_count] = y;
      kp_s[kp_count] = s;
      kp_count++;
    end
    if (!e) return;
    n = kp_count;
    kp_count = 0;
    if (n == 0) return;
    if (keep_limit == 0 || n <= keep_limit) begin
      for (int i = 0; i < n; i++) push_point(i, i + 1 == n);
      return;
    end
    for (int i = 0; i < n; i++) begin
      best = RADIUS_INF;
      for (int j = 0; j < n; j++) begin
        if (skey(kp_s[j]) > skey(kp_s[i])) begin
          dx = kp_x[i] > kp_x[j] ? kp_x[i] - kp_x[j] : kp_x[j] - kp_x[i];
          dy = kp_y[i] > kp_y[j] ? kp_y[i] - kp_y[j] : kp_y[j] - kp_y[i];
          d2 = RW'(dx) * RW'(dx) + RW'(dy) * RW'(dy);
          if (d2 < best) best = d2;
        end
      end
      kp_rad[i] = best;
    end
    for (int i = 0; i < n; i++) begin
      r = 0;
      for (int j = 0; j < n; j++)
        if (j != i && outranks(j, i)) r++;
      if (r < keep_limit) slot[r] = i;
    end
    for (int k = 0; k < keep_limit; k++) push_point(slot[k], k + 1 == keep_limit);
  endfunction

  // in_valid stays high from one transfer to the next; idling or drain drops it
  task automatic send_point(logic [15:0] x, logic [15:0] y, logic [31:0] s, logic e);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pos_x <= x;
    in_pos_y <= y;
    in_strength <= s;
    in_set_end <= e;
    do @(posedge clk); while (!in_ready);
    predict_selection(x, y, s, e);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (selected_q.size() != 0) @(posedge clk);
    // allow the back end to settle before touching config
    repeat (20) @(posedge clk);
  endtask

  task automatic set_limit(int v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v[6:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    keep_limit = v;
  endtask

  function automatic logic [31:0] rand_strength();
    case ($urandom_range(4))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'($urandom_range(7)) - 32'd3;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_set(int n, bit clustered);
    logic [15:0] bx, by;
    bx = 16'($urandom);
    by = 16'($urandom);
    for (int i = 0; i < n; i++) begin
      if (clustered)
        send_point(bx + 16'($urandom_range(31)), by + 16'($urandom_range(31)),
                   rand_strength(), i == n - 1);
      else
        send_point(16'($urandom), 16'($urandom), rand_strength(), i == n - 1);
    end
  endtask

  task automatic test_directed();
    set_limit(0);
    send_point(16'h0000, 16'h0000, 32'h8000_0000, 1'b0);
    send_point(16'hFFFF, 16'hFFFF, 32'h7FFF_FFFF, 1'b1);
    send_point(16'h1234, 16'h4321, 32'h0, 1'b1);  // single-point set
    set_limit(2);
    // equal strengths: all infinite radius, ties by index
    send_point(16'h0010, 16'h0010, 32'h5, 1'b0);
    send_point(16'h0020, 16'h0020, 32'h5, 1'b0);
    send_point(16'h0030, 16'h0030, 32'h5, 1'b1);
    // extreme distance
    send_point(16'h0000, 16'h0000, 32'h7FFF_FFFF, 1'b0);
    send_point(16'hFFFF, 16'hFFFF, 32'h8000_0000, 1'b0);
    send_point(16'hFFFF, 16'h0000, 32'hFFFF_FFFF, 1'b0);
    send_point(16'h0001, 16'h0001, 32'h0000_0001, 1'b1);
    set_limit(64);  // limit above set size
    send_set(5, 1'b0);
    set_limit(1);
    send_set(4, 1'b1);
  endtask

  task automatic test_overflow();
    set_limit(3);
    for (int i = 0; i < NPTS + 4; i++)
      send_point(16'($urandom), 16'($urandom), rand_strength(), i == NPTS + 3);
    set_limit(0);
    for (int i = 0; i < NPTS + 2; i++)
      send_point(16'($urandom), 16'($urandom), $urandom, i == NPTS + 1);
  endtask

  task automatic test_random(int items);
    int sent, n, lim;
    sent = 0;
    while (sent < items) begin
      lim = ($urandom_range(9) == 0) ? $urandom_range(64) : $urandom_range(8);
      set_limit(lim);
      n = ($urandom_range(19) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
      send_set(n, $urandom_range(1));
      sent += n;
    end
  endtask

  task automatic test_pause();
    set_limit(4);
    send_set(8, 1'b1);
    drain();
    send_set(6, 1'b0);
  endtask

  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    kp_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (selected_q.size() == 0) begin
        $display("%0t: unexpected result x=%h y=%h s=%h idx=%0d end=%b", $time,
                 out_x, out_y, out_strength, out_source_index, out_run_end);
        errors++;
      end else begin
        want = selected_q.pop_front();
        if (out_x !== want.x || out_y !== want.y || out_strength !== want.s ||
            out_source_index !== want.idx || out_run_end !== want.run_end) begin
          $display("%0t: mismatch exp x=%h y=%h s=%h idx=%0d end=%b", $time,
                   want.x, want.y, want.s, want.idx, want.run_end);
          $display("%0t:          got x=%h y=%h s=%h idx=%0d end=%b", $time,
                   out_x, out_y, out_strength, out_source_index, out_run_end);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("FAIL adaptive_nonmax_suppression");
      $finish;
    end
  end

  initial begin
    errors = 0;
    kp_count = 0;
    keep_limit = 0;
    idle_cycles = 0;
    timed_out = 1'b0;
    send_idle_pct = 31;
    recv_idle_pct = 80;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_overflow();
    test_random(60);
    send_idle_pct = 80;
    recv_idle_pct = 31;
    test_pause();
    test_random(60);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(60);
    set_limit(0);
    drain();
    if (errors == 0 && selected_q.size() == 0)
      $display("PASS adaptive_nonmax_suppression");
    else
      $display("FAIL adaptive_nonmax_suppression");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/anms_pkg.sv
rtl/anms_front.sv
rtl/anms_back.sv
rtl/adaptive_nonmax_suppression.sv
dv/tb_adaptive_nonmax_suppression.sv
